/* rtl/core/efsg_pkg.sv */
package efsg_pkg;

  // Fixed field widths of the request and span channels.
  localparam int DIM_W   = 8;
  localparam int ORG_W   = 15;
  localparam int COORD_W = 16;

  typedef struct packed {
    logic load;    // capture a request and clear the per-request state
    logic square;  // form the squared sizes and the pair count
    logic prep;    // form the first accumulator increments
    logic step;    // grow the inset by one
    logic emit;    // load the output register with the current pair
  } efsg_cmd_t;

  typedef struct packed {
    logic empty;      // the captured box has a zero side
    logic grow;       // the inset must grow before the pair is emitted
    logic last_pair;  // the current pair is the final one
  } efsg_status_t;

endpackage

/* rtl/core/efsg_req_if.sv */
interface efsg_req_if import efsg_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [DIM_W-1:0]        width;
  logic [DIM_W-1:0]        height;
  logic signed [ORG_W-1:0] origin_x;
  logic signed [ORG_W-1:0] origin_y;

  modport source (output valid, width, height, origin_x, origin_y, input ready);
  modport sink (input valid, width, height, origin_x, origin_y, output ready);
endinterface

/* rtl/core/efsg_span_if.sv */
interface efsg_span_if import efsg_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      vertical;
  logic signed [COORD_W-1:0] span_start;
  logic signed [COORD_W-1:0] span_end;
  logic signed [COORD_W-1:0] line_a;
  logic signed [COORD_W-1:0] line_b;
  logic                      last;

  modport source (output valid, vertical, span_start, span_end, line_a, line_b, last,
                  input ready);
  modport sink (input valid, vertical, span_start, span_end, line_a, line_b, last,
                output ready);
endinterface

/* rtl/core/efsg_datapath.sv */
module efsg_datapath import efsg_pkg::*; #(
  parameter int MAX_SIZE = 128
) (
  input  logic                      clk,
  input  efsg_cmd_t                 cmd,
  output efsg_status_t              status,
  input  logic [DIM_W-1:0]          width,
  input  logic [DIM_W-1:0]          height,
  input  logic signed [ORG_W-1:0]   origin_x,
  input  logic signed [ORG_W-1:0]   origin_y,
  output logic                      vertical,
  output logic signed [COORD_W-1:0] span_start,
  output logic signed [COORD_W-1:0] span_end,
  output logic signed [COORD_W-1:0] line_a,
  output logic signed [COORD_W-1:0] line_b,
  output logic                      last
);

  localparam int SZ_W   = $clog2(MAX_SIZE + 1);
  localparam int SQ_W   = 2 * SZ_W;
  localparam int PAIR_W = $clog2((MAX_SIZE + 1) / 2 + 1);
  localparam int ACC_W  = 4 * SZ_W + 1;

  logic [DIM_W-1:0]        w_lim;
  logic [DIM_W-1:0]        h_lim;
  logic                    vert;
  logic [SZ_W-1:0]         major;
  logic [SZ_W-1:0]         minor;
  logic signed [ORG_W-1:0] omaj;
  logic signed [ORG_W-1:0] omin;
  logic [SQ_W-1:0]         maj2;
  logic [SQ_W-1:0]         min2;
  logic [PAIR_W-1:0]       pairs;
  logic [PAIR_W-1:0]       pair;
  logic [PAIR_W-1:0]       pair_next;
  logic [SZ_W-1:0]         inset;
  logic [3*SZ_W-1:0]       lprod;
  logic signed [ACC_W-1:0] left;
  logic signed [ACC_W-1:0] right;
  logic signed [ACC_W-1:0] ldelta;
  logic signed [ACC_W-1:0] rdelta;
  logic signed [ACC_W-1:0] min2x2;
  logic signed [ACC_W-1:0] maj2x2;
  logic signed [COORD_W-1:0] omaj_x;
  logic signed [COORD_W-1:0] omin_x;
  logic [COORD_W-1:0]      base;
  logic [COORD_W-1:0]      hi;

  assign w_lim = (width > DIM_W'(MAX_SIZE)) ? DIM_W'(MAX_SIZE) : width;
  assign h_lim = (height > DIM_W'(MAX_SIZE)) ? DIM_W'(MAX_SIZE) : height;

  assign lprod     = min2 * (major - SZ_W'(1));
  assign min2x2    = ACC_W'({min2, 1'b0});
  assign maj2x2    = ACC_W'({maj2, 1'b0});
  assign pair_next = pair + PAIR_W'(1);

  assign omaj_x = COORD_W'(omaj);
  assign omin_x = COORD_W'(omin);
  assign base   = COORD_W'((minor - SZ_W'(1)) >> 1);
  assign hi     = COORD_W'(minor >> 1);

  assign status.empty     = (major == '0) || (minor == '0);
  assign status.grow      = (left < right) && (inset < major);
  assign status.last_pair = (pair_next == pairs);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // Ties go to the column form, so a square box is drawn in columns.
      vert   <= !(w_lim > h_lim);
      major  <= (w_lim > h_lim) ? SZ_W'(w_lim) : SZ_W'(h_lim);
      minor  <= (w_lim > h_lim) ? SZ_W'(h_lim) : SZ_W'(w_lim);
      omaj   <= (w_lim > h_lim) ? origin_x : origin_y;
      omin   <= (w_lim > h_lim) ? origin_y : origin_x;
      left   <= '0;
      right  <= '0;
      inset  <= '0;
      pair   <= '0;
    end
    if (cmd.square) begin
      maj2  <= major * major;
      min2  <= minor * minor;
      pairs <= PAIR_W'(({1'b0, minor} + (SZ_W + 1)'(1)) >> 1);
    end
    if (cmd.prep) begin
      // The left increment falls by twice min2 per inset step, the right one
      // rises by twice maj2 per pair, so the loops need only adders.
      ldelta <= ACC_W'(lprod);
      rdelta <= ACC_W'(maj2);
    end
    if (cmd.step) begin
      left   <= left + ldelta;
      ldelta <= ldelta - min2x2;
      inset  <= inset + SZ_W'(1);
    end
    if (cmd.emit) begin
      vertical   <= vert;
      span_start <= omaj_x + COORD_W'(inset);
      span_end   <= omaj_x + COORD_W'(major) - COORD_W'(inset);
      line_a     <= omin_x + base - COORD_W'(pair);
      line_b     <= omin_x + hi + COORD_W'(pair);
      last       <= status.last_pair;
      right      <= right + rdelta;
      rdelta     <= rdelta + maj2x2;
      pair       <= pair_next;
    end
  end

endmodule

/* rtl/core/efsg_controller.sv */
module efsg_controller import efsg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output efsg_cmd_t    cmd,
  input  efsg_status_t status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SQUARE = 2'd1;
  localparam logic [1:0] S_PREP   = 2'd2;
  localparam logic [1:0] S_GROW   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        if (status.empty) begin
          state_next = S_IDLE;
        end else begin
          cmd.square = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_GROW;
      end
      S_GROW: begin
        if (status.grow) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.emit = 1'b1;
          if (status.last_pair) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_goes_to_square: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SQUARE))
    else $error("accepted request did not start the setup");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_pair) |=> (state == S_IDLE && out_valid))
    else $error("final pair did not end the request");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output became valid without an emitted pair");

  a_step_stays: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (state == S_GROW))
    else $error("inset step left the pair loop");

endmodule

/* rtl/core/filled_ellipse_span_generator.sv */
// Filled ellipse span generator.
// The req channel takes one draw request: box width, height and top-left
// corner. The span channel returns the mirrored line pairs that fill the
// ellipse, from the middle of the box outward, the final pair with last set.
// A wide box gives row spans, any other box column spans.
// A request is taken only while the block is idle. After the transfer the
// block forms the squared sizes, then the first increments, and then grows
// the inset as needed before each pair; each further pair also waits for
// its own inset steps. A box with a zero side gives no spans and frees the
// block from the squaring state. The result sits in an output register, so
// a stalled receiver only holds the loop when the next pair is ready to
// go; the last pair of a request may wait there while the next request is
// accepted. Reset clears the controller and the output valid; sides above
// MAX_SIZE are clamped to it.
module filled_ellipse_span_generator import efsg_pkg::*; #(
  parameter int MAX_SIZE = 128
) (
  input logic         clk,
  input logic         rst,
  efsg_req_if.sink    req,
  efsg_span_if.source span
);

  efsg_cmd_t    cmd;
  efsg_status_t status;

  efsg_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (span.valid),
    .out_ready (span.ready),
    .cmd       (cmd),
    .status    (status)
  );

  efsg_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .width      (req.width),
    .height     (req.height),
    .origin_x   (req.origin_x),
    .origin_y   (req.origin_y),
    .vertical   (span.vertical),
    .span_start (span.span_start),
    .span_end   (span.span_end),
    .line_a     (span.line_a),
    .line_b     (span.line_b),
    .last       (span.last)
  );

endmodule
